// ===== rtl/prl_pkg.sv =====
// Shared types and constants for the prime range lister.
// Holds the transaction payload structs, status codes, sequencer states and
// the request/response structs between the sequencer and the remainder unit.
`default_nettype none

package prl_pkg;

    localparam int VAL_W   = 10;             // width of a range end and a candidate
    localparam int PV_W    = 9;              // width of the reported prime
    localparam int ST_W    = 3;              // width of the status code
    localparam int SQ_W    = VAL_W + 1;      // running square of the trial divisor
    localparam int CNT_W   = $clog2(VAL_W + 1);
    localparam int MAX_RESULTS = 54;         // primes reported per request at most
    localparam int COUNT_W = 6;

    localparam logic [ST_W-1:0] STATUS_PRIME    = 3'd0;
    localparam logic [ST_W-1:0] STATUS_NONE     = 3'd1;
    localparam logic [ST_W-1:0] STATUS_BAD_LOW  = 3'd2;
    localparam logic [ST_W-1:0] STATUS_BAD_HIGH = 3'd3;
    localparam logic [ST_W-1:0] STATUS_ORDER    = 3'd4;

    localparam logic [VAL_W-1:0] D_INIT  = VAL_W'(2);
    localparam logic [SQ_W-1:0]  SQ_INIT = SQ_W'(4);

    typedef struct packed {
        logic [VAL_W-1:0] range_low;
        logic [VAL_W-1:0] range_high;
    } range_req_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [PV_W-1:0] prime_value;
        logic            last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_TEST,
        ST_WAIT,
        ST_FOUND,
        ST_NEXT,
        ST_FLUSH
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/prl_rem_unit.sv =====
// Bit-serial restoring remainder unit for the prime range lister.
// Depends on prl_pkg for widths and the request/response structs.
`default_nettype none

module prl_rem_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire prl_pkg::rem_req_t req,
    output prl_pkg::rem_rsp_t      rsp
);

    logic                          busy_reg, busy_next;
    logic [prl_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [prl_pkg::VAL_W-1:0]     rem_reg, rem_next;
    logic [prl_pkg::VAL_W-1:0]     dq_reg, dq_next;
    logic [prl_pkg::VAL_W-1:0]     dv_reg, dv_next;
    logic                          done_reg, done_next;
    logic                          zero_reg, zero_next;

    logic [prl_pkg::VAL_W:0]       shifted;
    logic [prl_pkg::VAL_W:0]       diff;
    logic [prl_pkg::VAL_W-1:0]     rem_step;

    // one quotient bit per cycle: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted  = {rem_reg, dq_reg[prl_pkg::VAL_W-1]};
        diff     = shifted - {1'b0, dv_reg};
        rem_step = (shifted >= {1'b0, dv_reg}) ? diff[prl_pkg::VAL_W-1:0]
                                               : shifted[prl_pkg::VAL_W-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dv_next   = dv_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = prl_pkg::CNT_W'(prl_pkg::VAL_W);
            rem_next  = '0;
            dq_next   = req.dividend;
            dv_next   = req.divisor;
        end else if (busy_reg) begin
            rem_next = rem_step;
            dq_next  = {dq_reg[prl_pkg::VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - prl_pkg::CNT_W'(1);
            if (cnt_reg == prl_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                zero_next = (rem_step == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        dv_reg   <= dv_next;
        zero_reg <= zero_next;
    end

    assign rsp = '{done: done_reg, zero: zero_reg};

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("remainder unit started while busy");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("remainder unit did not go busy after start");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("remainder done without a finished pass");
`endif

endmodule

`default_nettype wire

// ===== rtl/prime_range_lister.sv =====
// Prime range lister: a rejected range is answered from the error state with one error result; a
// valid range tests each candidate against trial divisors d with d*d <= n on the single bit-serial
// remainder unit, candidate by candidate from range_low, until range_high or MAX_RESULTS primes.
// One request at a time: s_ready is high only while the sequencer is idle.
// aresetn is synchronous, active low; it clears the sequencer, output valid and unit control.
// Depends on prl_pkg and prl_rem_unit.
`default_nettype none

module prime_range_lister #(
    parameter int MAX_VALUE = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire prl_pkg::range_req_t s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output prl_pkg::result_t         m_data
);

    localparam logic [prl_pkg::VAL_W-1:0] MAX_V = prl_pkg::VAL_W'(MAX_VALUE);

    prl_pkg::seq_state_t             state_reg, state_next;
    logic [prl_pkg::VAL_W-1:0]       n_reg, n_next;       // current candidate
    logic [prl_pkg::VAL_W-1:0]       hi_reg, hi_next;
    logic [prl_pkg::VAL_W-1:0]       d_reg, d_next;       // trial divisor
    logic [prl_pkg::SQ_W-1:0]        sq_reg, sq_next;     // d_reg squared, kept by increments
    logic [prl_pkg::ST_W-1:0]        err_reg, err_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [prl_pkg::PV_W-1:0]        pend_val_reg, pend_val_next;
    logic [prl_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                            m_valid_reg, m_valid_next;
    prl_pkg::result_t                m_data_reg, m_data_next;

    logic                            slot_free;
    logic                            emit;
    prl_pkg::result_t                emit_data;
    logic [prl_pkg::ST_W-1:0]        chk_status;
    logic                            chk_bad;

    prl_pkg::rem_req_t               rem_req;
    prl_pkg::rem_rsp_t               rem_rsp;

    prl_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    // the output register can take a new transaction when empty or being drained
    assign slot_free = !m_valid_reg || m_ready;

    // range checks in priority order: low end, high end, then ordering
    always_comb begin
        chk_bad    = 1'b1;
        chk_status = prl_pkg::STATUS_BAD_LOW;
        priority if (s_data.range_low <= prl_pkg::VAL_W'(1) || s_data.range_low > MAX_V) begin
            chk_status = prl_pkg::STATUS_BAD_LOW;
        end else if (s_data.range_high < prl_pkg::VAL_W'(1) || s_data.range_high > MAX_V) begin
            chk_status = prl_pkg::STATUS_BAD_HIGH;
        end else if (s_data.range_low >= s_data.range_high) begin
            chk_status = prl_pkg::STATUS_ORDER;
        end else begin
            chk_bad = 1'b0;
        end
    end

    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        hi_next         = hi_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_val_next   = pend_val_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        emit_data       = '{status: prl_pkg::STATUS_PRIME, prime_value: '0, last: 1'b0};
        rem_req         = '{start: 1'b0, dividend: n_reg, divisor: d_reg};
        s_ready         = 1'b0;

        unique case (state_reg)
            prl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    n_next          = s_data.range_low;
                    hi_next         = s_data.range_high;
                    d_next          = prl_pkg::D_INIT;
                    sq_next         = prl_pkg::SQ_INIT;
                    err_next        = chk_status;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    state_next      = chk_bad ? prl_pkg::ST_ERR : prl_pkg::ST_TEST;
                end
            end
            prl_pkg::ST_ERR: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_data  = '{status: err_reg, prime_value: '0, last: 1'b1};
                    state_next = prl_pkg::ST_IDLE;
                end
            end
            prl_pkg::ST_TEST: begin
                // no divisor left with d*d <= n: the candidate is prime
                if (sq_reg > {1'b0, n_reg}) begin
                    state_next = prl_pkg::ST_FOUND;
                end else begin
                    rem_req.start = 1'b1;
                    state_next    = prl_pkg::ST_WAIT;
                end
            end
            prl_pkg::ST_WAIT: begin
                if (rem_rsp.done) begin
                    if (rem_rsp.zero) begin
                        state_next = prl_pkg::ST_NEXT;
                    end else begin
                        d_next     = d_reg + prl_pkg::VAL_W'(1);
                        sq_next    = sq_reg + {d_reg, 1'b1};
                        state_next = prl_pkg::ST_TEST;
                    end
                end
            end
            prl_pkg::ST_FOUND: begin
                // hold the new prime back; only the next find or the end says if it is last
                if (!pend_valid_reg || slot_free) begin
                    if (pend_valid_reg) begin
                        emit      = 1'b1;
                        emit_data = '{status: prl_pkg::STATUS_PRIME,
                                      prime_value: pend_val_reg, last: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_val_next   = n_reg[prl_pkg::PV_W-1:0];
                    count_next      = count_reg + prl_pkg::COUNT_W'(1);
                    if (count_reg == prl_pkg::COUNT_W'(prl_pkg::MAX_RESULTS - 1)) begin
                        state_next = prl_pkg::ST_FLUSH;
                    end else begin
                        state_next = prl_pkg::ST_NEXT;
                    end
                end
            end
            prl_pkg::ST_NEXT: begin
                if (n_reg == hi_reg) begin
                    state_next = prl_pkg::ST_FLUSH;
                end else begin
                    n_next     = n_reg + prl_pkg::VAL_W'(1);
                    d_next     = prl_pkg::D_INIT;
                    sq_next    = prl_pkg::SQ_INIT;
                    state_next = prl_pkg::ST_TEST;
                end
            end
            prl_pkg::ST_FLUSH: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (pend_valid_reg) begin
                        emit_data = '{status: prl_pkg::STATUS_PRIME,
                                      prime_value: pend_val_reg, last: 1'b1};
                    end else begin
                        emit_data = '{status: prl_pkg::STATUS_NONE, prime_value: '0, last: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = prl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = prl_pkg::ST_IDLE;
            end
        endcase
    end

    // output register: load on emit, drop valid once the transaction is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= prl_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        hi_reg       <= hi_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        err_reg      <= err_next;
        pend_val_reg <= pend_val_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("pending prime left over at idle");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= prl_pkg::COUNT_W'(prl_pkg::MAX_RESULTS))
        else $error("prime count beyond limit");

    a_square_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prl_pkg::ST_TEST) |-> (sq_reg == ({1'b0, d_reg} * {1'b0, d_reg})))
        else $error("running square lost track of divisor");

    a_nonprime_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != prl_pkg::STATUS_PRIME)
            |-> (m_data_reg.last && m_data_reg.prime_value == '0))
        else $error("error or none-found result not final or not zero");
`endif

endmodule

`default_nettype wire
